### hw/rtl/citg_pkg.sv
package citg_pkg;

  // command codes on the input stream
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WR_A    = 2'd1;
  localparam logic [1:0] CMD_WR_B    = 2'd2;
  localparam logic [1:0] CMD_GATES_B = 2'd3;

  // register select: 0..2 count byte of a channel, 3 control word
  localparam logic [1:0] REG_CTRL = 2'd3;

  // access modes
  localparam logic [1:0] AM_LATCH = 2'd0;
  localparam logic [1:0] AM_LO    = 2'd1;
  localparam logic [1:0] AM_HI    = 2'd2;
  localparam logic [1:0] AM_LOHI  = 2'd3;

  // count modes that actually count
  localparam logic [2:0] MODE_INT_ON_TC = 3'd0;
  localparam logic [2:0] MODE_SQ_WAVE   = 3'd3;
  localparam logic [2:0] MODE_SW_STROBE = 3'd4;

  localparam int unsigned NUM_CH         = 3;
  localparam int unsigned CNT_W          = 16;
  localparam int unsigned SAMPLE_W       = 14;
  localparam logic [SAMPLE_W-1:0] TONE_LEVEL = 14'h2828;

  localparam int unsigned PRESCALE_DEF = 228;
  localparam int unsigned TPS_DEF      = 16;

  // per-channel strobes for one step
  typedef struct packed {
    logic       tick;
    logic       cw_we;
    logic       cnt_we;
    logic       gate_we;
    logic       gate;
    logic [7:0] data;
  } chan_ctl_t;

  // bytes expected for a count load, keep old value in latch mode
  function automatic logic [1:0] bytes_for_access(input logic [1:0] am,
                                                  input logic [1:0] keep);
    logic [1:0] res;
    case (am)
      AM_LO, AM_HI: res = 2'd1;
      AM_LOHI:      res = 2'd2;
      default:      res = keep;
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/citg_chan.sv
module citg_chan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  citg_pkg::chan_ctl_t ctl_i,
  output logic                level_o    // output level after this step
);
  import citg_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d, rld_q, rld_d, dec, rld_new;
  logic [2:0]       mode_q, mode_d;
  logic [1:0]       am_q, am_d, left_q, left_d;
  logic             gate_q, gate_d, out_q, out_d, en_q, en_d, gate_eff, rld_ok;

  assign gate_eff = ctl_i.gate_we ? ctl_i.gate : gate_q;
  assign dec      = cnt_q - CNT_W'(1);

  // new reload value from a count byte
  always_comb begin
    rld_new = rld_q;
    rld_ok  = 1'b1;
    case (am_q)
      AM_LO:   rld_new = {rld_q[15:8], ctl_i.data};
      AM_HI:   rld_new = {ctl_i.data, rld_q[7:0]};
      AM_LOHI: rld_new = {ctl_i.data, rld_q[15:8]};
      default: rld_ok  = 1'b0;
    endcase
  end

  // count, control word and count byte handling
  always_comb begin
    cnt_d  = cnt_q;
    rld_d  = rld_q;
    mode_d = mode_q;
    am_d   = am_q;
    left_d = left_q;
    gate_d = gate_eff;
    out_d  = out_q;
    en_d   = en_q;

    if (ctl_i.tick && en_q && gate_eff) begin
      case (mode_q)
        MODE_INT_ON_TC: begin
          cnt_d = dec;
          if (dec == '1) out_d = 1'b1;
        end
        MODE_SQ_WAVE: begin
          out_d = (dec < (rld_q >> 1)) ? 1'b0 : 1'b1;
          cnt_d = (dec == '1) ? rld_q : dec;
        end
        MODE_SW_STROBE: begin
          cnt_d = dec;
          if (dec == '0) out_d = 1'b1;
          if (dec == '1) begin
            en_d  = 1'b0;
            out_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (ctl_i.cw_we) begin
      mode_d = ctl_i.data[3:1];
      am_d   = ctl_i.data[5:4];
      left_d = bytes_for_access(ctl_i.data[5:4], left_q);
      case (ctl_i.data[3:1])
        MODE_INT_ON_TC: begin
          out_d = 1'b0;
          en_d  = 1'b0;
        end
        MODE_SQ_WAVE:   out_d = 1'b1;
        MODE_SW_STROBE: begin
          out_d = 1'b1;
          en_d  = 1'b0;
        end
        default: ;
      endcase
    end

    if (ctl_i.cnt_we && rld_ok) begin
      rld_d = rld_new;
      if (mode_q == MODE_INT_ON_TC) en_d = 1'b0;
      if (left_q > 2'd1) begin
        left_d = left_q - 2'd1;
      end else begin
        left_d = bytes_for_access(am_q, left_q);
        if (mode_q == MODE_INT_ON_TC || mode_q == MODE_SQ_WAVE ||
            mode_q == MODE_SW_STROBE) begin
          cnt_d = rld_new;
          en_d  = 1'b1;
        end
      end
    end
  end

  assign level_o = out_d;

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rld_q  <= '0;
      mode_q <= '0;
      am_q   <= '0;
      left_q <= '0;
      gate_q <= 1'b0;
      out_q  <= 1'b0;
      en_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      rld_q  <= rld_d;
      mode_q <= mode_d;
      am_q   <= am_d;
      left_q <= left_d;
      gate_q <= gate_d;
      out_q  <= out_d;
      en_q   <= en_d;
    end
  end

endmodule

### hw/rtl/cascaded_interval_timer_tone_gen_unit.sv
// Tone generator built from two three-channel interval timers, A and B.
// Input stream: one word per bus event, either a clock tick, a byte written
// to timer A or timer B (count byte or control word), or the gates of
// timer B. Every PRESCALE-th tick timer B counts and its outputs become
// timer A's gates; timer A counts on every tick.
// Output stream: one sample word every TICKS_PER_SAMPLE ticks, 0x2828 if
// during that window channel 2 of timer A was high while channels 0 and 1
// were low, else 0. Writes and other ticks give no output word.
// Throughput: one input word per cycle while the output register is not
// stalled; all six channels update in parallel in the single processing
// stage after the input register. The tick closing the window passes the
// input register, then the output register, which holds the valid sample.
// Reset clears all timer state, the prescaler and the window; no word is
// pending afterwards. When the receiver stalls with a sample waiting, the
// next word still enters the input register and waits there; further
// input is held off until the output register frees up.
module cascaded_interval_timer_tone_gen_unit #(
  parameter int unsigned PRESCALE         = citg_pkg::PRESCALE_DEF,
  parameter int unsigned TICKS_PER_SAMPLE = citg_pkg::TPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // cmd[1:0], reg_req[3:2], data[11:4], zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // sample[13:0], zero
);
  import citg_pkg::*;

  localparam int unsigned PRESC_W = $clog2(PRESCALE);
  localparam int unsigned PHASE_W = (TICKS_PER_SAMPLE > 1) ? $clog2(TICKS_PER_SAMPLE) : 1;
  localparam logic [PRESC_W-1:0] PRESC_LAST = PRESC_W'(PRESCALE - 1);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICKS_PER_SAMPLE - 1);

  logic                in_valid_q;
  logic [1:0]          cmd_q, reg_q;
  logic [7:0]          data_q;
  logic                process, is_tick, wrap, win_end, hit, any_next;
  logic [PRESC_W-1:0]  presc_q, presc_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                any_q, any_d;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] sample_q;
  chan_ctl_t           ctl_a [NUM_CH];
  chan_ctl_t           ctl_b [NUM_CH];
  logic [NUM_CH-1:0]   lvl_a, lvl_b;

  // the stage works on its word when the output register can take a result
  assign process         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || process;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cmd_q      <= '0;
      reg_q      <= '0;
      data_q     <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        cmd_q  <= s_axis_tdata_i[1:0];
        reg_q  <= s_axis_tdata_i[3:2];
        data_q <= s_axis_tdata_i[11:4];
      end
      in_valid_q <= (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !process);
    end
  end

  assign is_tick = process && (cmd_q == CMD_TICK);
  assign wrap    = is_tick && (presc_q == PRESC_LAST);
  assign win_end = is_tick && (phase_q == PHASE_LAST);

  // strobes for each channel
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      ctl_a[i].tick    = is_tick;
      ctl_a[i].cw_we   = process && cmd_q == CMD_WR_A && reg_q == REG_CTRL &&
                         data_q[7:6] == 2'(i);
      ctl_a[i].cnt_we  = process && cmd_q == CMD_WR_A && reg_q == 2'(i);
      ctl_a[i].gate_we = wrap;
      ctl_a[i].gate    = lvl_b[i];
      ctl_a[i].data    = data_q;

      ctl_b[i].tick    = wrap;
      ctl_b[i].cw_we   = process && cmd_q == CMD_WR_B && reg_q == REG_CTRL &&
                         data_q[7:6] == 2'(i);
      ctl_b[i].cnt_we  = process && cmd_q == CMD_WR_B && reg_q == 2'(i);
      ctl_b[i].gate_we = process && cmd_q == CMD_GATES_B;
      ctl_b[i].gate    = data_q[i];
      ctl_b[i].data    = data_q;
    end
  end

  // timer channels
  for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
    citg_chan u_chan_a (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_a[g]),
      .level_o (lvl_a[g])
    );
    citg_chan u_chan_b (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_b[g]),
      .level_o (lvl_b[g])
    );
  end

  // prescaler and sample window
  assign hit      = lvl_a[2] && !lvl_a[0] && !lvl_a[1];
  assign any_next = any_q || hit;

  always_comb begin
    presc_d = presc_q;
    phase_d = phase_q;
    any_d   = any_q;
    if (is_tick) begin
      presc_d = wrap ? '0 : presc_q + PRESC_W'(1);
      phase_d = win_end ? '0 : phase_q + PHASE_W'(1);
      any_d   = win_end ? 1'b0 : any_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= '0;
      phase_q <= '0;
      any_q   <= 1'b0;
    end else begin
      presc_q <= presc_d;
      phase_q <= phase_d;
      any_q   <= any_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else if (win_end) begin
      out_valid_q <= 1'b1;
      sample_q    <= any_next ? TONE_LEVEL : '0;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - SAMPLE_W){1'b0}}, sample_q};

  // checks
  a_sample_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sample_q == '0 || sample_q == TONE_LEVEL))
    else $error("sample word is neither silence nor tone level");

  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    presc_q <= PRESC_LAST)
    else $error("prescaler ran past its last count");

  a_sample_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(is_tick && phase_q == PHASE_LAST))
    else $error("sample word without a closing tick");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import citg_pkg::*;

  // control word channel select with no channel behind it
  localparam logic [1:0] SEL_NONE = 2'd3;
  localparam int unsigned ALL_CH = 2 * NUM_CH;
  localparam int unsigned ITEMS_TOTAL = 1300;
  localparam int unsigned HOLD_LONG = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;  // cmd[1:0], reg_req[3:2], data[11:4], zero
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;       // sample[13:0], zero

  cascaded_interval_timer_tone_gen_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timer state, index 0..2 timer A, 3..5 timer B
  logic [CNT_W-1:0] tmr_cnt[ALL_CH];
  logic [CNT_W-1:0] tmr_reload[ALL_CH];
  logic [2:0] tmr_mode[ALL_CH];
  logic [1:0] tmr_access[ALL_CH];
  logic tmr_bcd[ALL_CH];
  logic tmr_gate[ALL_CH];
  logic tmr_out[ALL_CH];
  logic [1:0] tmr_left[ALL_CH];
  logic tmr_run[ALL_CH];
  logic [7:0] presc_cnt;
  int unsigned win_phase;
  logic win_hit;

  logic [SAMPLE_W-1:0] sample_q[$];
  logic [SAMPLE_W-1:0] exp_sample;
  int unsigned words_sent = 0;
  int unsigned err_cnt = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int unsigned rx_hold_len = 0;

  // byte count of a load, latch mode keeps the old count
  function automatic logic [1:0] load_bytes(input logic [1:0] am, input logic [1:0] keep);
    case (am)
      AM_LO, AM_HI: return 2'd1;
      AM_LOHI: return 2'd2;
      default: return keep;
    endcase
  endfunction

  function automatic logic [7:0] ctrl_word(input logic [1:0] sel, input logic [1:0] am,
                                           input logic [2:0] mode, input logic bcd);
    return {sel, am, mode, bcd};
  endfunction

  // one count step of a channel, only when running and gated
  function automatic void count_channel(input int c);
    if (!tmr_run[c] || !tmr_gate[c]) return;
    case (tmr_mode[c])
      MODE_INT_ON_TC: begin
        tmr_cnt[c] = tmr_cnt[c] - 16'd1;
        if (tmr_cnt[c] == 16'hffff) tmr_out[c] = 1'b1;
      end
      MODE_SQ_WAVE: begin
        tmr_cnt[c] = tmr_cnt[c] - 16'd1;
        tmr_out[c] = (tmr_cnt[c] < (tmr_reload[c] >> 1)) ? 1'b0 : 1'b1;
        if (tmr_cnt[c] == 16'hffff) tmr_cnt[c] = tmr_reload[c];
      end
      MODE_SW_STROBE: begin
        tmr_cnt[c] = tmr_cnt[c] - 16'd1;
        if (tmr_cnt[c] == 16'h0000) tmr_out[c] = 1'b1;
        if (tmr_cnt[c] == 16'hffff) begin
          tmr_run[c] = 1'b0;
          tmr_out[c] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // bus write of a control word or count byte to one timer
  function automatic void write_timer(input int base, input logic [1:0] rsel,
                                      input logic [7:0] val);
    int c;
    if (rsel == REG_CTRL) begin
      if (val[7:6] == SEL_NONE) return;
      c = base + int'(val[7:6]);
      tmr_bcd[c] = val[0];
      tmr_mode[c] = val[3:1];
      tmr_access[c] = val[5:4];
      tmr_left[c] = load_bytes(tmr_access[c], tmr_left[c]);
      if (tmr_mode[c] == MODE_INT_ON_TC) begin
        tmr_out[c] = 1'b0;
        tmr_run[c] = 1'b0;
      end else if (tmr_mode[c] == MODE_SQ_WAVE) begin
        tmr_out[c] = 1'b1;
      end else if (tmr_mode[c] == MODE_SW_STROBE) begin
        tmr_out[c] = 1'b1;
        tmr_run[c] = 1'b0;
      end
      return;
    end
    c = base + int'(rsel);
    case (tmr_access[c])
      AM_LO: tmr_reload[c] = {tmr_reload[c][15:8], val};
      AM_HI: tmr_reload[c] = {val, tmr_reload[c][7:0]};
      AM_LOHI: tmr_reload[c] = {val, tmr_reload[c][15:8]};
      default: return;
    endcase
    if (tmr_mode[c] == MODE_INT_ON_TC) tmr_run[c] = 1'b0;
    if (tmr_left[c] > 2'd1) begin
      tmr_left[c] = tmr_left[c] - 2'd1;
      return;
    end
    tmr_left[c] = load_bytes(tmr_access[c], tmr_left[c]);
    if (tmr_mode[c] == MODE_INT_ON_TC || tmr_mode[c] == MODE_SQ_WAVE ||
        tmr_mode[c] == MODE_SW_STROBE) begin
      tmr_cnt[c] = tmr_reload[c];
      tmr_run[c] = 1'b1;
    end
  endfunction

  // advance the timers by one word, returns 1 when a sample closes
  function automatic bit predict_sample(input logic [1:0] cmd, input logic [1:0] rsel,
                                        input logic [7:0] val,
                                        output logic [SAMPLE_W-1:0] smp);
    int i;
    smp = '0;
    case (cmd)
      CMD_WR_A: begin
        write_timer(0, rsel, val);
        return 1'b0;
      end
      CMD_WR_B: begin
        write_timer(NUM_CH, rsel, val);
        return 1'b0;
      end
      CMD_GATES_B: begin
        for (i = 0; i < NUM_CH; i++) tmr_gate[NUM_CH + i] = val[i];
        return 1'b0;
      end
      default: ;
    endcase
    presc_cnt = presc_cnt + 8'd1;
    if (presc_cnt == 8'(PRESCALE_DEF)) begin
      presc_cnt = '0;
      for (i = NUM_CH; i < ALL_CH; i++) count_channel(i);
      for (i = 0; i < NUM_CH; i++) tmr_gate[i] = tmr_out[NUM_CH + i];
    end
    for (i = 0; i < NUM_CH; i++) count_channel(i);
    if (tmr_out[2] && !tmr_out[0] && !tmr_out[1]) win_hit = 1'b1;
    win_phase++;
    if (win_phase >= TPS_DEF) begin
      smp = win_hit ? TONE_LEVEL : '0;
      win_phase = 0;
      win_hit = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_timers();
    int i;
    for (i = 0; i < ALL_CH; i++) begin
      tmr_cnt[i] = '0;
      tmr_reload[i] = '0;
      tmr_mode[i] = '0;
      tmr_access[i] = AM_LATCH;
      tmr_bcd[i] = 1'b0;
      tmr_gate[i] = 1'b0;
      tmr_out[i] = 1'b0;
      tmr_left[i] = '0;
      tmr_run[i] = 1'b0;
    end
    presc_cnt = '0;
    win_phase = 0;
    win_hit = 1'b0;
  endfunction

  task automatic note_error(input string msg);
    if (err_cnt < 10) $display("[%0t] %s", $realtime, msg);
    err_cnt++;
  endtask

  // offer one word after a random gap, predict once it is taken
  task automatic send_word(input logic [1:0] cmd, input logic [1:0] rsel,
                           input logic [7:0] val);
    int unsigned gap;
    logic [SAMPLE_W-1:0] smp;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0000, val, rsel, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_sample(cmd, rsel, val, smp)) sample_q.push_back(smp);
    words_sent++;
  endtask

  // ticks with random content in the ignored fields
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(CMD_TICK, 2'($urandom), 8'($urandom));
  endtask

  // control word then the count bytes its access mode asks for
  task automatic program_channel(input bit on_b, input int unsigned ch, input logic [1:0] am,
                                 input logic [2:0] mode, input logic bcd,
                                 input logic [15:0] count);
    logic [1:0] cmd;
    cmd = on_b ? CMD_WR_B : CMD_WR_A;
    send_word(cmd, REG_CTRL, ctrl_word(2'(ch), am, mode, bcd));
    case (am)
      AM_HI: send_word(cmd, 2'(ch), count[15:8]);
      AM_LOHI: begin
        send_word(cmd, 2'(ch), count[7:0]);
        send_word(cmd, 2'(ch), count[15:8]);
      end
      default: send_word(cmd, 2'(ch), count[7:0]);
    endcase
  endtask

  // stop offering and wait for every pending sample
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
  endtask

  // field extremes, ignored writes and every command
  task automatic test_directed();
    send_word(CMD_TICK, REG_CTRL, 8'hff);
    // count byte while the channel is still in latch mode
    send_word(CMD_WR_A, 2'd0, 8'hff);
    // control words that select no channel
    send_word(CMD_WR_A, REG_CTRL, 8'hff);
    send_word(CMD_WR_B, REG_CTRL, ctrl_word(SEL_NONE, AM_LOHI, MODE_SQ_WAVE, 1'b0));
    // latch access keeps the byte count
    send_word(CMD_WR_A, REG_CTRL, ctrl_word(2'd0, AM_LATCH, MODE_INT_ON_TC, 1'b0));
    // mode that never counts, byte stored without a load
    program_channel(1'b0, 1, AM_LO, 3'd5, 1'b1, 16'h00aa);
    program_channel(1'b0, 2, AM_LOHI, MODE_SQ_WAVE, 1'b0, 16'h0004);
    program_channel(1'b0, 0, AM_HI, MODE_INT_ON_TC, 1'b0, 16'hff00);
    program_channel(1'b0, 1, AM_LO, MODE_SW_STROBE, 1'b1, 16'h0000);
    program_channel(1'b1, 0, AM_LO, MODE_SQ_WAVE, 1'b0, 16'h0002);
    program_channel(1'b1, 1, AM_HI, MODE_SW_STROBE, 1'b0, 16'h0100);
    program_channel(1'b1, 2, AM_LOHI, MODE_INT_ON_TC, 1'b1, 16'hffff);
    send_word(CMD_GATES_B, 2'd0, 8'h00);
    send_word(CMD_GATES_B, 2'd3, 8'hff);
    send_word(CMD_GATES_B, 2'd1, 8'h07);
  endtask

  // tone windows across a prescaler wrap, no idling on either side
  task automatic test_tone_windows();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    program_channel(1'b0, 1, AM_LO, MODE_INT_ON_TC, 1'b0, 16'h0008);
    send_ticks(250);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_drained();
  endtask

  // long receiver stall while ticks keep coming
  task automatic test_backpressure();
    rx_hold_len = HOLD_LONG;
    send_ticks(120);
    wait_drained();
  endtask

  // programming sequences followed by tick runs, plus raw noise words
  task automatic test_random();
    bit on_b;
    int unsigned ch;
    logic [1:0] am;
    logic [2:0] mode;
    logic [15:0] count;
    while (words_sent < ITEMS_TOTAL) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        on_b = ($urandom_range(0, 3) == 0);
        ch = $urandom_range(0, 2);
        am = ($urandom_range(0, 15) == 0) ? AM_LATCH : 2'($urandom_range(1, 3));
        case ($urandom_range(0, 7))
          0, 1, 2: mode = MODE_INT_ON_TC;
          3, 4: mode = MODE_SQ_WAVE;
          5, 6: mode = MODE_SW_STROBE;
          default: mode = 3'($urandom);
        endcase
        count = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        program_channel(on_b, ch, am, mode, 1'($urandom), count);
        if ($urandom_range(0, 3) == 0) send_word(CMD_GATES_B, 2'($urandom), 8'($urandom));
        send_ticks($urandom_range(4, 60));
      end else begin
        repeat ($urandom_range(1, 4)) send_word(2'($urandom), 2'($urandom), 8'($urandom));
      end
    end
  endtask

  // receiver: random stall per word, or one long hold when requested
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      if (rx_hold_len > 0) begin
        stall = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 5) : 0;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // compare each accepted sample word with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (sample_q.size() == 0) begin
        note_error($sformatf("unexpected sample %0d", m_axis_tdata_o[SAMPLE_W-1:0]));
      end else begin
        exp_sample = sample_q.pop_front();
        if (m_axis_tdata_o[SAMPLE_W-1:0] !== exp_sample)
          note_error($sformatf("sample mismatch: expected %0d, got %0d",
                               exp_sample, m_axis_tdata_o[SAMPLE_W-1:0]));
      end
    end
  end

  initial begin
    clear_timers();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_tone_windows();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/citg_pkg.sv
hw/rtl/citg_chan.sv
hw/rtl/cascaded_interval_timer_tone_gen_unit.sv
tb/tb.sv
